@@ hdl/kect_pkg.sv @@
// Package: shared types, constants and key decode for the keypad countdown timer.
`timescale 1ns / 1ps

package kect_pkg;

  localparam int unsigned KeyW      = 4;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CountW    = 2;
  localparam int unsigned MinW      = 7;
  localparam int unsigned SecW      = 6;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [DigitW-1:0] NoDigit   = 4'hF;
  localparam logic [CountW-1:0] LastSlot  = 2'd3;
  localparam logic [6:0]        SecsPerMin = 7'd60;
  localparam logic [SecW-1:0]   MaxSec    = 6'd59;

  localparam logic FuncKey  = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key_index;
  } item_t;

  typedef struct packed {
    logic              alarm;
    logic              key_beep;
    logic [SecW-1:0]   show_seconds;
    logic [MinW-1:0]   show_minutes;
    logic [CountW-1:0] digits_entered;
    logic              mode;
  } result_t;

  function automatic logic [DigitW-1:0] key_digit(input logic [KeyW-1:0] key);
    logic [DigitW-1:0] d;
    case (key) inside
      [4'd0:4'd8]: d = key + 4'd1;
      4'd10:       d = 4'd0;
      default:     d = NoDigit;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/kect_in_reg.sv @@
// Input register stage: capture one event transaction and hold it for the core.
`timescale 1ns / 1ps

module kect_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  kect_pkg::item_t     in_item,
  output logic                item_valid,
  input  logic                item_take,
  output kect_pkg::item_t     item
);

  logic            valid_r, valid_nxt;
  kect_pkg::item_t item_r;

  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ hdl/kect_core.sv @@
// Timer core: digit entry, count load, countdown and the result of each event.
`timescale 1ns / 1ps

module kect_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  kect_pkg::item_t     item,
  output kect_pkg::result_t   result
);

  logic                                running_r, running_nxt;
  logic [kect_pkg::CountW-1:0]         count_r, count_nxt;
  logic [kect_pkg::MinW-1:0]           min_r, min_nxt;
  logic [kect_pkg::SecW-1:0]           sec_r, sec_nxt;
  logic [kect_pkg::DigitW-1:0]         digit_r [3];
  logic                                store_en;
  logic [kect_pkg::DigitW-1:0]         d;
  logic [6:0]                          load_min, load_sec;
  logic                                beep, alarm;

  assign d = kect_pkg::key_digit(item.key_index);

  always_comb begin
    load_min = 7'(digit_r[0]) * 7'd10 + 7'(digit_r[1]);
    load_sec = 7'(digit_r[2]) * 7'd10 + 7'(d);
  end

  always_comb begin
    running_nxt = running_r;
    count_nxt   = count_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    store_en    = 1'b0;
    beep        = 1'b0;
    alarm       = 1'b0;
    if (item.func == kect_pkg::FuncTick) begin
      if (running_r) begin
        if (sec_r != '0) begin
          sec_nxt = sec_r - 1'b1;
        end else if (min_r != '0) begin
          min_nxt = min_r - 1'b1;
          sec_nxt = kect_pkg::MaxSec;
        end
        if ((min_nxt == '0) && (sec_nxt == '0)) begin
          running_nxt = 1'b0;
          alarm       = 1'b1;
        end
      end
    end else if (!running_r && (d != kect_pkg::NoDigit)) begin
      beep = 1'b1;
      if (count_r != kect_pkg::LastSlot) begin
        store_en  = 1'b1;
        count_nxt = count_r + 1'b1;
      end else begin
        count_nxt = '0;
        if (load_sec >= kect_pkg::SecsPerMin) begin
          min_nxt = load_min + 1'b1;
          sec_nxt = kect_pkg::SecW'(load_sec - kect_pkg::SecsPerMin);
        end else begin
          min_nxt = load_min;
          sec_nxt = load_sec[kect_pkg::SecW-1:0];
        end
        if ((min_nxt == '0) && (sec_nxt == '0)) begin
          alarm = 1'b1;
        end else begin
          running_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.mode           = running_nxt;
    result.digits_entered = count_nxt;
    result.show_minutes   = min_nxt;
    result.show_seconds   = sec_nxt;
    result.key_beep       = beep;
    result.alarm          = alarm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      count_r   <= '0;
      min_r     <= '0;
      sec_r     <= '0;
    end else if (fire) begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
      min_r     <= min_nxt;
      sec_r     <= sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_en) begin
      digit_r[count_r] <= d;
    end
  end

endmodule

@@ hdl/keypad_entry_countdown_timer.sv @@
// Top level: keypad entry countdown timer with input and result registers.
//
//  channel | dir | ports                       | content
//  --------+-----+-----------------------------+---------------------------------
//  in      | in  | in_tvalid/tready/tdata/tuser | key_index in tdata, func in tuser
//  out     | out | out_tvalid/tready/tdata      | one result per event
//
// Each event passes from input to result through the input register, while the core
// works on it, and then the result register. A new event is taken every
// cycle while the result side keeps up. Reset clears the count, digit count and
// mode; stored digits hold no reset value. A stalled result holds both stages.
`timescale 1ns / 1ps

module keypad_entry_countdown_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] key_index, [7:4] zero
  input  logic [kect_pkg::InDataW-1:0]    in_tdata,
  // [0] func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] mode, [2:1] digits_entered, [9:3] show_minutes, [15:10] show_seconds,
  // [16] key_beep, [17] alarm, [23:18] zero
  output logic [kect_pkg::OutDataW-1:0]   out_tdata
);

  kect_pkg::item_t   in_item, item;
  kect_pkg::result_t result;
  logic              item_valid, out_free, fire;
  logic              out_valid_r, out_valid_nxt;
  kect_pkg::result_t out_r;

  assign in_item.func      = in_tuser;
  assign in_item.key_index = in_tdata[kect_pkg::KeyW-1:0];

  assign out_free = !out_valid_r || out_tready;
  assign fire     = item_valid && out_free;

  kect_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (out_free),
    .item       (item)
  );

  kect_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = kect_pkg::OutDataW'(out_r);

endmodule

@@ sim/tb_keypad_entry_countdown_timer.sv @@
// Testbench: random and directed keypad/tick events against a built-in timer predictor.
`timescale 1ns / 1ps

class countdown_scoreboard;
  logic [1:0]          digit_cnt;
  logic [3:0]          digit_store [3];
  bit                  running;
  logic [12:0]         secs_left;
  kect_pkg::result_t   pending_q [$];
  int                  errors;
  int                  n_events;
  int                  n_results;
  int                  n_loads;
  int                  n_alarms;
  int                  n_beeps;

  function new();
    digit_cnt = '0;
    running   = 1'b0;
    secs_left = '0;
    errors    = 0;
    n_events  = 0;
    n_results = 0;
    n_loads   = 0;
    n_alarms  = 0;
    n_beeps   = 0;
  endfunction

  function logic [3:0] digit_of(input logic [3:0] k);
    if (k == 4'd10) return 4'd0;
    if (k < 4'd9) return k + 4'd1;
    return kect_pkg::NoDigit;
  endfunction

  function void note_event(input kect_pkg::item_t ev);
    kect_pkg::result_t r;
    logic [3:0]        d;
    int                load;
    r = '0;
    if (ev.func == kect_pkg::FuncTick) begin
      if (running) begin
        if (secs_left != 0) secs_left = secs_left - 13'd1;
        if (secs_left == 0) begin
          running = 1'b0;
          r.alarm = 1'b1;
        end
      end
    end else if (!running) begin
      d = digit_of(ev.key_index);
      if (d != kect_pkg::NoDigit) begin
        r.key_beep = 1'b1;
        if (digit_cnt != kect_pkg::LastSlot) begin
          digit_store[digit_cnt] = d;
          digit_cnt = digit_cnt + 2'd1;
        end else begin
          load = (int'(digit_store[0]) * 10 + int'(digit_store[1])) * 60
               + int'(digit_store[2]) * 10 + int'(d);
          digit_cnt = '0;
          secs_left = load[12:0];
          n_loads++;
          if (secs_left == 0) r.alarm = 1'b1;
          else running = 1'b1;
        end
      end
    end
    r.mode           = running;
    r.digits_entered = digit_cnt;
    r.show_minutes   = 7'(secs_left / 60);
    r.show_seconds   = 6'(secs_left % 60);
    if (r.alarm) n_alarms++;
    if (r.key_beep) n_beeps++;
    n_events++;
    pending_q.push_back(r);
  endfunction

  function void check_result(input logic [23:0] data);
    kect_pkg::result_t got;
    kect_pkg::result_t want;
    got = data[17:0];
    n_results++;
    if (pending_q.size() == 0) begin
      $error("result %h arrived with no event outstanding", data);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (data[23:18] !== 6'd0) begin
      $error("pad: expected 0, got %0h", data[23:18]);
      errors++;
    end
    if (got.mode !== want.mode) begin
      $error("mode: expected %0d, got %0d", want.mode, got.mode);
      errors++;
    end
    if (got.digits_entered !== want.digits_entered) begin
      $error("digits_entered: expected %0d, got %0d", want.digits_entered, got.digits_entered);
      errors++;
    end
    if (got.show_minutes !== want.show_minutes) begin
      $error("show_minutes: expected %0d, got %0d", want.show_minutes, got.show_minutes);
      errors++;
    end
    if (got.show_seconds !== want.show_seconds) begin
      $error("show_seconds: expected %0d, got %0d", want.show_seconds, got.show_seconds);
      errors++;
    end
    if (got.key_beep !== want.key_beep) begin
      $error("key_beep: expected %0d, got %0d", want.key_beep, got.key_beep);
      errors++;
    end
    if (got.alarm !== want.alarm) begin
      $error("alarm: expected %0d, got %0d", want.alarm, got.alarm);
      errors++;
    end
  endfunction

  function int pending();
    return pending_q.size();
  endfunction
endclass

module tb_keypad_entry_countdown_timer;

  localparam logic [3:0] KeyStar    = 4'd9;
  localparam logic [3:0] KeyZero    = 4'd10;
  localparam logic [3:0] KeyHash    = 4'd11;
  localparam int         StallLimit = 2000;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [kect_pkg::InDataW-1:0]  in_tdata   = '0;
  logic                          in_tuser   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [kect_pkg::OutDataW-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent        = 0;
  int quiet_cycles  = 0;

  countdown_scoreboard sb = new();

  keypad_entry_countdown_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic f, input logic [3:0] k);
    kect_pkg::item_t ev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'b0000, k};
    do @(posedge clk); while (!in_tready);
    ev.func      = f;
    ev.key_index = k;
    sb.note_event(ev);
    n_sent++;
  endtask

  task automatic press_digit(input int d);
    send_event(kect_pkg::FuncKey, (d == 0) ? KeyZero : 4'(d - 1));
  endtask

  task automatic tick();
    send_event(kect_pkg::FuncTick, 4'($urandom_range(15)));
  endtask

  task automatic ignored_event();
    int pick;
    pick = $urandom_range(6);
    if (pick == 0) tick();
    else if (pick == 1) send_event(kect_pkg::FuncKey, KeyStar);
    else send_event(kect_pkg::FuncKey, KeyHash + 4'(pick - 2));
  endtask

  // Enter MMSS, then tick it down to the alarm with dropped keys mixed in.
  task automatic run_session();
    int dig [4];
    dig[0] = 0;
    dig[1] = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
    dig[2] = ($urandom_range(2) == 0) ? $urandom_range(9) : $urandom_range(2);
    dig[3] = $urandom_range(9);
    if ($urandom_range(19) == 0) begin
      dig[1] = 0;
      dig[2] = 0;
      dig[3] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      while ($urandom_range(99) < 15) ignored_event();
      press_digit(dig[i]);
    end
    while (sb.running) begin
      if ($urandom_range(99) < 15) send_event(kect_pkg::FuncKey, 4'($urandom_range(15)));
      else tick();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 80;
    tick();
    for (int k = 12; k < 16; k++) send_event(kect_pkg::FuncKey, 4'(k));
    send_event(kect_pkg::FuncKey, KeyStar);
    send_event(kect_pkg::FuncKey, KeyHash);
    repeat (4) press_digit(0);
    press_digit(0);
    press_digit(0);
    press_digit(0);
    press_digit(2);
    send_event(kect_pkg::FuncKey, 4'd4);
    send_event(kect_pkg::FuncKey, KeyStar);
    tick();
    tick();
    while (n_sent < 400) run_session();

    send_idle_pct = 80;
    recv_idle_pct = 37;
    while (n_sent < 800) run_session();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (n_sent < 1200) run_session();
    repeat (4) press_digit(9);
    repeat (3) tick();
    send_event(kect_pkg::FuncKey, 4'd5);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d events, %0d results, %0d beeps", sb.n_events, sb.n_results,
             sb.n_beeps);
    $display("covered %0d countdown loads, %0d alarms, %0d mismatches", sb.n_loads,
             sb.n_alarms, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/kect_pkg.sv
hdl/kect_in_reg.sv
hdl/kect_core.sv
hdl/keypad_entry_countdown_timer.sv
sim/tb_keypad_entry_countdown_timer.sv
